### design/pthsc_pkg.sv
// ----------------------------------------------------------------------------
// pthsc_pkg
// Shared types, constants and arithmetic helpers of the compensation core.
// ----------------------------------------------------------------------------
package pthsc_pkg;

  // Datapath widths
  localparam int unsigned DP_W      = 64;
  localparam int unsigned DIVR_W    = 31;
  localparam int unsigned DIV_STEPS = DP_W;

  // Stage counts of each unit
  localparam int unsigned TEMP_LAT  = 4;
  localparam int unsigned PRESS_LAT = 9 + DIV_STEPS + 7;
  localparam int unsigned HUM_LAT   = 11;
  localparam int unsigned LAT_TOTAL = TEMP_LAT + PRESS_LAT;

  // Compensation constants
  localparam logic [32:0] PRESS_BIAS_T   = 33'd128000;
  localparam logic [20:0] PRESS_ADC_FULL = 21'd1048576;
  localparam logic [31:0] PRESS_SCALE    = 32'd3125;
  localparam logic [63:0] PRESS_C_BIAS   = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HUM_BIAS_T     = 32'd76800;
  localparam logic [31:0] HUM_CLAMP_MAX  = 32'd419430400;
  localparam logic [31:0] HUM_OFFSET_A   = 32'd2097152;
  localparam logic [31:0] HUM_ROUND_A    = 32'd16384;
  localparam logic [31:0] HUM_OFFSET_B   = 32'd32768;
  localparam logic [31:0] HUM_ROUND_B    = 32'd8192;
  localparam logic [16:0] HUM_OUT_MAX    = 17'd102400;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEMP       = 3'd0,
    CFG_PRESS_LOW  = 3'd1,
    CFG_PRESS_HIGH = 3'd2,
    CFG_PRESS_NINE = 3'd3,
    CFG_HUM_LOW    = 3'd4,
    CFG_HUM_HIGH   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
  } temp_cal_t;

  typedef struct packed {
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } press_cal_t;

  typedef struct packed {
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
    logic signed [7:0]  h6;
  } hum_cal_t;

  // Sideband that travels with a quotient through the divider
  typedef struct packed {
    logic qneg;
    logic dz;
  } div_side_t;

  function automatic logic signed [16:0] sx17(logic signed [15:0] v);
    return {v[15], v};
  endfunction

  function automatic logic [31:0] sx32(logic signed [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx64(logic signed [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Unsigned 32-bit word times signed 17-bit coefficient, sign-extended to 64
  function automatic logic [63:0] mul_u32s17(logic [31:0] u, logic signed [16:0] s);
    logic signed [49:0] p;
    p = $signed({1'b0, u}) * s;
    return {{14{p[49]}}, p};
  endfunction

  // Low 32 bits of a product; signedness does not change them
  function automatic logic [31:0] mul_lo32(logic [31:0] a, logic [31:0] b);
    logic [31:0] p;
    p = a * b;
    return p;
  endfunction

endpackage

### design/pthsc_if.sv
// ----------------------------------------------------------------------------
// pthsc_if
// Valid/ready channels for raw samples and compensated results.
// ----------------------------------------------------------------------------
interface pthsc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] adc_temperature;
  logic [19:0] adc_pressure;
  logic [15:0] adc_humidity;

  modport source (output valid, adc_temperature, adc_pressure, adc_humidity,
                  input ready);
  modport sink   (input valid, adc_temperature, adc_pressure, adc_humidity,
                  output ready);
endinterface

interface pthsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_q24_8;
  logic        [16:0] humidity_q22_10;
  logic               divisor_zero;

  modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  divisor_zero, input ready);
  modport sink   (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  divisor_zero, output ready);
endinterface

### design/pth_sensor_compensation_core.sv
// Throughput: one sample per cycle while results are taken; the 64-step quotient pipeline in the
// pressure path sets the depth, and every stage advances together.
// A stalled result holds the whole pipeline until it is taken.
// Reset clears the stage valid bits and all calibration registers to zero.
// ----------------------------------------------------------------------------
// pth_sensor_compensation_core
// Pipelined temperature, pressure and humidity compensation engine.
// ----------------------------------------------------------------------------
module pth_sensor_compensation_core import pthsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  pthsc_in_if.sink    smp_i,
  pthsc_out_if.source res_o
);

  logic [47:0] tc_q;
  logic [63:0] pcl_q, pch_q;
  logic [15:0] p9_q;
  logic [31:0] hcl_q;
  logic [39:0] hch_q;

  logic [LAT_TOTAL-1:0] vld_q;
  logic                 adv;

  temp_cal_t  tcal;
  press_cal_t pcal;
  hum_cal_t   hcal;

  logic signed [31:0] tfine, temp;
  logic [19:0]        ap;
  logic [15:0]        ah;
  logic [31:0]        press;
  logic               dz;
  logic [16:0]        hum;

  logic signed [31:0] tdl_q [PRESS_LAT];
  logic [16:0]        hdl_q [PRESS_LAT-HUM_LAT];

  // Calibration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q  <= '0;
      pcl_q <= '0;
      pch_q <= '0;
      p9_q  <= '0;
      hcl_q <= '0;
      hch_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP:       tc_q  <= cfg_data_i[47:0];
        CFG_PRESS_LOW:  pcl_q <= cfg_data_i;
        CFG_PRESS_HIGH: pch_q <= cfg_data_i;
        CFG_PRESS_NINE: p9_q  <= cfg_data_i[15:0];
        CFG_HUM_LOW:    hcl_q <= cfg_data_i[31:0];
        CFG_HUM_HIGH:   hch_q <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficient fields
  assign tcal.t1 = tc_q[15:0];
  assign tcal.t2 = tc_q[31:16];
  assign tcal.t3 = tc_q[47:32];
  assign pcal.p1 = pcl_q[15:0];
  assign pcal.p2 = pcl_q[31:16];
  assign pcal.p3 = pcl_q[47:32];
  assign pcal.p4 = pcl_q[63:48];
  assign pcal.p5 = pch_q[15:0];
  assign pcal.p6 = pch_q[31:16];
  assign pcal.p7 = pch_q[47:32];
  assign pcal.p8 = pch_q[63:48];
  assign pcal.p9 = p9_q;
  assign hcal.h1 = hcl_q[7:0];
  assign hcal.h2 = hcl_q[23:8];
  assign hcal.h3 = hcl_q[31:24];
  assign hcal.h4 = hch_q[15:0];
  assign hcal.h5 = hch_q[31:16];
  assign hcal.h6 = hch_q[39:32];

  // Advance every stage unless the result waits
  assign adv         = !vld_q[LAT_TOTAL-1] || res_o.ready;
  assign smp_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT_TOTAL-2:0], smp_i.valid};
    end
  end

  pthsc_temp u_temp (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cal_i   (tcal),
    .adc_t_i (smp_i.adc_temperature),
    .adc_p_i (smp_i.adc_pressure),
    .adc_h_i (smp_i.adc_humidity),
    .tfine_o (tfine),
    .temp_o  (temp),
    .adc_p_o (ap),
    .adc_h_o (ah)
  );

  pthsc_press u_press (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cal_i   (pcal),
    .tfine_i (tfine),
    .adc_p_i (ap),
    .press_o (press),
    .dz_o    (dz)
  );

  pthsc_hum u_hum (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cal_i   (hcal),
    .tfine_i (tfine),
    .adc_h_i (ah),
    .hum_o   (hum)
  );

  // Align temperature and humidity with the longer pressure path
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdl_q[0] <= temp;
      for (int k = 1; k < PRESS_LAT; k++) begin
        tdl_q[k] <= tdl_q[k-1];
      end
      hdl_q[0] <= hum;
      for (int k = 1; k < PRESS_LAT - HUM_LAT; k++) begin
        hdl_q[k] <= hdl_q[k-1];
      end
    end
  end

  assign res_o.valid             = vld_q[LAT_TOTAL-1];
  assign res_o.temperature_centi = tdl_q[PRESS_LAT-1];
  assign res_o.pressure_q24_8    = press;
  assign res_o.humidity_q22_10   = hdl_q[PRESS_LAT-HUM_LAT-1];
  assign res_o.divisor_zero      = dz;

`ifndef SYNTHESIS
  a_stall_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !smp_i.ready)
    else $error("input taken while result stalled");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_i.valid && smp_i.ready) |=> vld_q[0])
    else $error("accepted sample missing from first stage");

  a_dz_zero_press : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.divisor_zero) |-> (res_o.pressure_q24_8 == 32'd0))
    else $error("pressure not forced to zero on zero divisor");

  a_hum_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.humidity_q22_10 <= HUM_OUT_MAX))
    else $error("humidity above clamp");
`endif

endmodule

### design/pthsc_temp.sv
// ----------------------------------------------------------------------------
// pthsc_temp
// Four-stage fine temperature pipeline; carries the other raw codes along.
// ----------------------------------------------------------------------------
module pthsc_temp import pthsc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  temp_cal_t          cal_i,
  input  logic [19:0]        adc_t_i,
  input  logic [19:0]        adc_p_i,
  input  logic [15:0]        adc_h_i,
  output logic signed [31:0] tfine_o,
  output logic signed [31:0] temp_o,
  output logic [19:0]        adc_p_o,
  output logic [15:0]        adc_h_o
);

  logic signed [17:0] x1_q;
  logic signed [16:0] d_q;
  logic signed [33:0] m1_q, dd_q;
  logic signed [22:0] v1_q;
  logic signed [37:0] m2_q;
  logic signed [31:0] tf_q, temp_q;
  logic [19:0] ap_q [TEMP_LAT];
  logic [15:0] ah_q [TEMP_LAT];

  logic signed [23:0] v2;
  logic signed [31:0] tf_d;
  logic signed [35:0] t36, t5;

  // Fine temperature and centi-degree result
  assign v2   = m2_q[37:14];
  assign tf_d = {{9{v1_q[22]}}, v1_q} + {{8{v2[23]}}, v2};
  assign t36  = {{4{tf_d[31]}}, tf_d};
  assign t5   = (t36 <<< 2) + t36 + 36'sd128;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: offsets from t1
      x1_q <= $signed({1'b0, adc_t_i[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});
      d_q  <= $signed({1'b0, adc_t_i[19:4]}) - $signed({1'b0, cal_i.t1});
      // stage 2: linear and square terms
      m1_q <= x1_q * cal_i.t2;
      dd_q <= d_q * d_q;
      // stage 3: scale and apply t3
      v1_q <= m1_q[33:11];
      m2_q <= $signed(dd_q[33:12]) * cal_i.t3;
      // stage 4: sum
      tf_q   <= tf_d;
      temp_q <= {{4{t5[35]}}, t5[35:8]};
    end
  end

  // Carry the raw pressure and humidity codes alongside
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ap_q[0] <= adc_p_i;
      ah_q[0] <= adc_h_i;
      for (int k = 1; k < TEMP_LAT; k++) begin
        ap_q[k] <= ap_q[k-1];
        ah_q[k] <= ah_q[k-1];
      end
    end
  end

  assign tfine_o = tf_q;
  assign temp_o  = temp_q;
  assign adc_p_o = ap_q[TEMP_LAT-1];
  assign adc_h_o = ah_q[TEMP_LAT-1];

endmodule

### design/pthsc_div.sv
// ----------------------------------------------------------------------------
// pthsc_div
// Pipelined restoring divider: one quotient bit per stage, unsigned operands.
// ----------------------------------------------------------------------------
module pthsc_div import pthsc_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DP_W-1:0]   dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  input  div_side_t         side_i,
  output logic [DP_W-1:0]   quot_o,
  output div_side_t         side_o
);

  logic [DIVR_W-1:0] rem_q  [DIV_STEPS];
  logic [DP_W-1:0]   wrk_q  [DIV_STEPS];
  logic [DIVR_W-1:0] dvs_q  [DIV_STEPS];
  div_side_t         side_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DIVR_W-1:0] rem_in, dvs_in;
    logic [DP_W-1:0]   wrk_in;
    div_side_t         side_in;
    logic [DIVR_W:0]   trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign wrk_in  = dividend_i;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign wrk_in  = wrk_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down the next dividend bit and try the subtract
    assign trial = {rem_in, wrk_in[DP_W-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        wrk_q[k]  <= {wrk_in[DP_W-2:0], ge};
        dvs_q[k]  <= dvs_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign quot_o = wrk_q[DIV_STEPS-1];
  assign side_o = side_q[DIV_STEPS-1];

endmodule

### design/pthsc_press.sv
// ----------------------------------------------------------------------------
// pthsc_press
// Pressure pipeline: 64-bit wrapping datapath, split products, divider.
// ----------------------------------------------------------------------------
module pthsc_press import pthsc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  press_cal_t         cal_i,
  input  logic signed [31:0] tfine_i,
  input  logic [19:0]        adc_p_i,
  output logic [31:0]        press_o,
  output logic               dz_o
);

  // stage 1..9 registers
  logic signed [32:0] a_q;
  logic [20:0]        pr_q [5];
  logic [63:0]        aa_q, ap5_q [3], ap2_q [3];
  logic [63:0]        b6lo_q, c3lo_q;
  logic [31:0]        b6hi_q, c3hi_q;
  logic [63:0]        b1_q, x3_q, b_q, c_q;
  logic [63:0]        cplo_q, num_q, cp_q, nlo_q, nm_q, ma_q;
  logic [31:0]        cphi_q, nhi_q;
  logic [30:0]        dv_q, mb_q;
  div_side_t          side_q;

  // after the divider
  div_side_t   dside;
  logic [63:0] quot;
  logic [63:0] p_q [5];
  logic        dz_q [7];
  logic [63:0] sll_q, p8lo_q, ss_q, bb_q, p9lo_q, bq_q [2], aq_q, sum_q;
  logic [31:0] slh_q, p8hi_q, p9hi_q, press_q;

  logic signed [65:0] aa_full;
  logic signed [48:0] ap5_full, ap2_full;
  logic [63:0]        s, t, p9sum, p7s;

  assign aa_full  = a_q * a_q;
  assign ap5_full = a_q * cal_i.p5;
  assign ap2_full = a_q * cal_i.p2;

  // Front end up to the divider operands
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: bias the fine temperature
      a_q     <= {tfine_i[31], tfine_i} - $signed(PRESS_BIAS_T);
      pr_q[0] <= PRESS_ADC_FULL - {1'b0, adc_p_i};
      // stage 2: square and linear terms
      aa_q     <= aa_full[63:0];
      ap5_q[0] <= {{15{ap5_full[48]}}, ap5_full};
      ap2_q[0] <= {{15{ap2_full[48]}}, ap2_full};
      pr_q[1]  <= pr_q[0];
      // stage 3: partial products of the square with p6 and p3
      b6lo_q   <= mul_u32s17(aa_q[31:0], sx17(cal_i.p6));
      b6hi_q   <= mul_lo32(aa_q[63:32], sx32(cal_i.p6));
      c3lo_q   <= mul_u32s17(aa_q[31:0], sx17(cal_i.p3));
      c3hi_q   <= mul_lo32(aa_q[63:32], sx32(cal_i.p3));
      ap5_q[1] <= ap5_q[0];
      ap2_q[1] <= ap2_q[0];
      pr_q[2]  <= pr_q[1];
      // stage 4: combine partials
      b1_q     <= b6lo_q + {b6hi_q, 32'b0};
      x3_q     <= c3lo_q + {c3hi_q, 32'b0};
      ap5_q[2] <= ap5_q[1];
      ap2_q[2] <= ap2_q[1];
      pr_q[3]  <= pr_q[2];
      // stage 5: offset and sensitivity sums
      b_q     <= b1_q + (ap5_q[2] << 17) + (sx64(cal_i.p4) << 35);
      c_q     <= 64'($signed(x3_q) >>> 8) + (ap2_q[2] << 12) + PRESS_C_BIAS;
      pr_q[4] <= pr_q[3];
      // stage 6: sensitivity times p1, numerator
      cplo_q <= mul_u32s17(c_q[31:0], {1'b0, cal_i.p1});
      cphi_q <= mul_lo32(c_q[63:32], {16'b0, cal_i.p1});
      num_q  <= {12'b0, pr_q[4], 31'b0} - b_q;
      // stage 7: combine divisor, scale numerator
      cp_q  <= cplo_q + {cphi_q, 32'b0};
      nlo_q <= mul_u32s17(num_q[31:0], 17'(PRESS_SCALE));
      nhi_q <= mul_lo32(num_q[63:32], PRESS_SCALE);
      // stage 8: divisor is the top 31 bits after the shift by 33
      dv_q <= cp_q[63:33];
      nm_q <= nlo_q + {nhi_q, 32'b0};
      // stage 9: magnitudes and signs
      ma_q        <= nm_q[63] ? (64'd0 - nm_q) : nm_q;
      mb_q        <= dv_q[30] ? (31'd0 - dv_q) : dv_q;
      side_q.qneg <= nm_q[63] ^ dv_q[30];
      side_q.dz   <= (dv_q == '0);
    end
  end

  pthsc_div u_div (
    .clk_i      (clk_i),
    .en_i       (en_i),
    .dividend_i (ma_q),
    .divisor_i  (mb_q),
    .side_i     (side_q),
    .quot_o     (quot),
    .side_o     (dside)
  );

  assign s     = 64'($signed(p_q[0]) >>> 13);
  assign t     = 64'($signed(ss_q) >>> 13);
  assign p9sum = p9lo_q + {p9hi_q, 32'b0};
  assign p7s   = sx64(cal_i.p7) << 4;

  // Back end: quadratic and linear corrections
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: restore the quotient sign
      p_q[0]  <= dside.qneg ? (64'd0 - quot) : quot;
      dz_q[0] <= dside.dz;
      // stage 2: square of p/2^13 and p8 partials
      sll_q   <= s[31:0] * s[31:0];
      slh_q   <= mul_lo32(s[31:0], s[63:32]);
      p8lo_q  <= mul_u32s17(p_q[0][31:0], sx17(cal_i.p8));
      p8hi_q  <= mul_lo32(p_q[0][63:32], sx32(cal_i.p8));
      p_q[1]  <= p_q[0];
      dz_q[1] <= dz_q[0];
      // stage 3: combine
      ss_q    <= sll_q + {slh_q[30:0], 33'b0};
      bb_q    <= p8lo_q + {p8hi_q, 32'b0};
      p_q[2]  <= p_q[1];
      dz_q[2] <= dz_q[1];
      // stage 4: p9 partials
      p9lo_q   <= mul_u32s17(t[31:0], sx17(cal_i.p9));
      p9hi_q   <= mul_lo32(t[63:32], sx32(cal_i.p9));
      bq_q[0]  <= 64'($signed(bb_q) >>> 19);
      p_q[3]   <= p_q[2];
      dz_q[3]  <= dz_q[2];
      // stage 5: quadratic term
      aq_q    <= 64'($signed(p9sum) >>> 25);
      bq_q[1] <= bq_q[0];
      p_q[4]  <= p_q[3];
      dz_q[4] <= dz_q[3];
      // stage 6: sum of terms
      sum_q   <= p_q[4] + aq_q + bq_q[1];
      dz_q[5] <= dz_q[4];
      // stage 7: scale, add p7 offset, force zero on a zero divisor
      press_q <= dz_q[5] ? 32'd0 : (sum_q[39:8] + p7s[31:0]);
      dz_q[6] <= dz_q[5];
    end
  end

  assign press_o = press_q;
  assign dz_o    = dz_q[6];

endmodule

### design/pthsc_hum.sv
// ----------------------------------------------------------------------------
// pthsc_hum
// Humidity pipeline: 32-bit wrapping datapath.
// ----------------------------------------------------------------------------
module pthsc_hum import pthsc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  hum_cal_t           cal_i,
  input  logic signed [31:0] tfine_i,
  input  logic [15:0]        adc_h_i,
  output logic [16:0]        hum_o
);

  logic [31:0] x_q, m5_q, hb0_q, hc0_q, hb_q, hc_q, m_q, hd_q, mh2_q, he_q;
  logic [31:0] hss_q, m7_q;
  logic [31:0] ha_q [5];
  logic [31:0] xx_q [3];
  logic [15:0] ah_q [2];
  logic [16:0] hum_q;

  logic [31:0] ha_sum, he_sum, hs, y, yc;

  assign ha_sum = {2'b0, ah_q[1], 14'b0} - (sx32(cal_i.h4) << 20) - m5_q + HUM_ROUND_A;
  assign he_sum = mh2_q + HUM_ROUND_B;
  assign hs     = 32'($signed(xx_q[0]) >>> 15);
  assign y      = xx_q[2] - 32'($signed(m7_q) >>> 4);

  // Clamp to 0..100 percent
  always_comb begin
    if (y[31]) begin
      yc = '0;
    end else if (y > HUM_CLAMP_MAX) begin
      yc = HUM_CLAMP_MAX;
    end else begin
      yc = y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: bias
      x_q     <= tfine_i - HUM_BIAS_T;
      ah_q[0] <= adc_h_i;
      // stage 2: temperature products
      m5_q    <= mul_lo32(sx32(cal_i.h5), x_q);
      hb0_q   <= mul_lo32(x_q, {{24{cal_i.h6[7]}}, cal_i.h6});
      hc0_q   <= mul_lo32(x_q, {24'b0, cal_i.h3});
      ah_q[1] <= ah_q[0];
      // stage 3: offset term and scaled factors
      ha_q[0] <= 32'($signed(ha_sum) >>> 15);
      hb_q    <= 32'($signed(hb0_q) >>> 10);
      hc_q    <= 32'($signed(hc0_q) >>> 11) + HUM_OFFSET_B;
      // stage 4
      m_q     <= mul_lo32(hb_q, hc_q);
      ha_q[1] <= ha_q[0];
      // stage 5
      hd_q    <= 32'($signed(m_q) >>> 10) + HUM_OFFSET_A;
      ha_q[2] <= ha_q[1];
      // stage 6
      mh2_q   <= mul_lo32(hd_q, sx32(cal_i.h2));
      ha_q[3] <= ha_q[2];
      // stage 7
      he_q    <= 32'($signed(he_sum) >>> 14);
      ha_q[4] <= ha_q[3];
      // stage 8
      xx_q[0] <= mul_lo32(ha_q[4], he_q);
      // stage 9
      hss_q   <= mul_lo32(hs, hs);
      xx_q[1] <= xx_q[0];
      // stage 10
      m7_q    <= mul_lo32(32'($signed(hss_q) >>> 7), {24'b0, cal_i.h1});
      xx_q[2] <= xx_q[1];
      // stage 11: subtract, clamp, drop fraction bits
      hum_q   <= yc[28:12];
    end
  end

  assign hum_o = hum_q;

endmodule

### sim/tb_pth_sensor_compensation_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pth_sensor_compensation_core
// Self-checking bench for the compensation core: drives raw frames with
// random gaps, predicts each compensated result in fixed point and compares
// the results in order, across several calibration settings.
// ----------------------------------------------------------------------------
module tb_pth_sensor_compensation_core;
  import pthsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned N_RANDOM    = 1200;
  localparam int unsigned DRAIN_WAIT  = 120;

  typedef struct packed {
    logic [19:0] at;
    logic [19:0] ap;
    logic [15:0] ah;
  } frame_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic        dz;
  } comp_t;

  // Directed row: frame, plus an optional fixed expectation
  typedef struct packed {
    frame_t frame;
    logic   fixed;
    comp_t  res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [63:0] cfg_data_i;

  pthsc_in_if  smp_if ();
  pthsc_out_if res_if ();

  pth_sensor_compensation_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_i      (smp_if.sink),
    .res_o      (res_if.source)
  );

  // Calibration shadow
  logic [47:0] cal_temp;
  logic [63:0] cal_plo, cal_phi;
  logic [15:0] cal_p9;
  logic [31:0] cal_hlo;
  logic [39:0] cal_hhi;

  comp_t expected_q[$];
  int unsigned n_err;
  int unsigned cyc;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sdiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic comp_t compensate(frame_t f);
    logic [63:0] at, ap, t1, t2, t3, v1, dd, v2, tf, p1, p2, p3, p4, p5, p6, p7, p8,
                 p9, a, b, p, s, tt;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb, hc, hd, he, hs, ah;
    comp_t r;
    at = {44'd0, f.at};
    ap = {44'd0, f.ap};
    ah = {16'd0, f.ah};
    t1 = {48'd0, cal_temp[15:0]};
    t2 = {{48{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{48{cal_temp[47]}}, cal_temp[47:32]};
    v1 = asr64(((at >> 3) - (t1 << 1)) * t2, 11);
    dd = (at >> 4) - t1;
    v2 = asr64(asr64(dd * dd, 12) * t3, 14);
    tf = v1 + v2;
    tt = asr64(tf * 5 + 128, 8);
    r.temp = tt[31:0];
    p1 = {48'd0, cal_plo[15:0]};
    p2 = {{48{cal_plo[31]}}, cal_plo[31:16]};
    p3 = {{48{cal_plo[47]}}, cal_plo[47:32]};
    p4 = {{48{cal_plo[63]}}, cal_plo[63:48]};
    p5 = {{48{cal_phi[15]}}, cal_phi[15:0]};
    p6 = {{48{cal_phi[31]}}, cal_phi[31:16]};
    p7 = {{48{cal_phi[47]}}, cal_phi[47:32]};
    p8 = {{48{cal_phi[63]}}, cal_phi[63:48]};
    p9 = {{48{cal_p9[15]}}, cal_p9};
    r.press = '0;
    r.dz = 1'b0;
    a = tf - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = asr64(a * a * p3, 8) + ((a * p2) << 12);
    a = asr64(((64'd1 << 47) + a) * p1, 33);
    if (a == 0) begin
      r.dz = 1'b1;
    end else begin
      p = 64'd1048576 - ap;
      p = sdiv64(((p << 31) - b) * 64'd3125, a);
      s = asr64(p, 13);
      a = asr64(p9 * asr64(s * s, 13), 25);
      b = asr64(p8 * p, 19);
      p = asr64(p + a + b, 8) + (p7 << 4);
      r.press = p[31:0];
    end
    h1 = {24'd0, cal_hlo[7:0]};
    h2 = {{16{cal_hlo[23]}}, cal_hlo[23:8]};
    h3 = {24'd0, cal_hlo[31:24]};
    h4 = {{16{cal_hhi[15]}}, cal_hhi[15:0]};
    h5 = {{16{cal_hhi[31]}}, cal_hhi[31:16]};
    h6 = {{24{cal_hhi[39]}}, cal_hhi[39:32]};
    x = tf[31:0] - 32'd76800;
    ha = asr32((ah << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    hb = asr32(x * h6, 10);
    hc = asr32(x * h3, 11) + 32'd32768;
    hd = asr32(hb * hc, 10) + 32'd2097152;
    he = asr32(hd * h2 + 32'd8192, 14);
    x = ha * he;
    hs = asr32(x, 15);
    x = x - asr32(asr32(hs * hs, 7) * h1, 4);
    if (x[31]) x = 0;
    else if (x > 32'd419430400) x = 32'd419430400;
    r.hum = x[28:12];
    return r;
  endfunction

  task automatic write_cal(cfg_idx_e idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TEMP:       cal_temp = val[47:0];
      CFG_PRESS_LOW:  cal_plo  = val;
      CFG_PRESS_HIGH: cal_phi  = val;
      CFG_PRESS_NINE: cal_p9   = val[15:0];
      CFG_HUM_LOW:    cal_hlo  = val[31:0];
      CFG_HUM_HIGH:   cal_hhi  = val[39:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Send one frame and queue its expected result; valid stays up for a
  // following frame and is dropped on a gap or before a drain
  task automatic send_frame(frame_t f);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_if.valid           <= 1'b1;
    smp_if.adc_temperature <= f.at;
    smp_if.adc_pressure    <= f.ap;
    smp_if.adc_humidity    <= f.ah;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    expected_q.push_back(compensate(f));
    @(negedge clk_i);
  endtask

  task automatic drain();
    smp_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // Typical-device calibration with random spread
  task automatic load_typical();
    write_cal(CFG_TEMP, {16'($signed(50) + $signed(16'($urandom_range(0, 100)))),
                         16'd26435 + 16'($urandom_range(0, 200)),
                         16'd27504 + 16'($urandom_range(0, 2000))});
    write_cal(CFG_PRESS_LOW, {16'd2855, 16'd3024, -16'sd10685,
                              16'd36477 + 16'($urandom_range(0, 500))});
    write_cal(CFG_PRESS_HIGH, {-16'sd7, 16'd15500, -16'sd7, 16'd140});
    write_cal(CFG_PRESS_NINE, 64'd6000);
    write_cal(CFG_HUM_LOW, {8'd0, 16'd362, 8'd75});
    write_cal(CFG_HUM_HIGH, {8'd30, 16'd50, 16'd318});
  endtask

  task automatic load_random();
    write_cal(CFG_TEMP, {$urandom, $urandom});
    write_cal(CFG_PRESS_LOW, {$urandom, $urandom});
    write_cal(CFG_PRESS_HIGH, {$urandom, $urandom});
    write_cal(CFG_PRESS_NINE, {$urandom, $urandom});
    write_cal(CFG_HUM_LOW, {$urandom, $urandom});
    write_cal(CFG_HUM_HIGH, {$urandom, $urandom});
  endtask

  // Result checker with random back-pressure
  initial begin
    int stall;
    comp_t exp_r;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0;
      res_if.ready <= (stall == 0);
      if (stall != 0) begin
        repeat (stall) @(negedge clk_i);
        res_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        n_err++;
      end else begin
        exp_r = expected_q.pop_front();
        if (res_if.temperature_centi !== exp_r.temp || res_if.pressure_q24_8 !== exp_r.press
            || res_if.humidity_q22_10 !== exp_r.hum || res_if.divisor_zero !== exp_r.dz) begin
          $display("%0t: mismatch exp t=%h p=%h h=%h z=%b got t=%h p=%h h=%h z=%b", $time,
                   exp_r.temp, exp_r.press, exp_r.hum, exp_r.dz,
                   res_if.temperature_centi, res_if.pressure_q24_8,
                   res_if.humidity_q22_10, res_if.divisor_zero);
          n_err++;
        end
      end
    end
  end

  row_t dir_rows[$];
  frame_t fr;

  initial begin
    comp_t zero_res;
    cyc = 0;
    n_err = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TEMP;
    cfg_data_i = '0;
    smp_if.valid = 1'b0;
    smp_if.adc_temperature = '0;
    smp_if.adc_pressure = '0;
    smp_if.adc_humidity = '0;
    cal_temp = '0; cal_plo = '0; cal_phi = '0; cal_p9 = '0; cal_hlo = '0; cal_hhi = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // After reset all coefficients are zero: divisor is zero, humidity comes out zero
    zero_res = '{temp: 32'd0, press: 32'd0, hum: 17'd0, dz: 1'b1};
    dir_rows.push_back('{frame: '{20'd0, 20'd0, 16'd0}, fixed: 1'b1, res: zero_res});
    dir_rows.push_back('{frame: '{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, fixed: 1'b1,
                         res: zero_res});
    foreach (dir_rows[i]) begin
      send_frame(dir_rows[i].frame);
      if (dir_rows[i].fixed) begin
        void'(expected_q.pop_back());
        expected_q.push_back(dir_rows[i].res);
      end
    end
    drain();

    // Typical calibration: a typical frame, extremes of each field and alternating bit patterns
    load_typical();
    dir_rows.delete();
    dir_rows.push_back('{frame: '{20'd519888, 20'd415148, 16'd27000}, fixed: 1'b0, res: '0});
    dir_rows.push_back('{frame: '{20'd0, 20'hFFFFF, 16'd0}, fixed: 1'b0, res: '0});
    dir_rows.push_back('{frame: '{20'hFFFFF, 20'd0, 16'hFFFF}, fixed: 1'b0, res: '0});
    dir_rows.push_back('{frame: '{20'h55555, 20'hAAAAA, 16'h5555}, fixed: 1'b0, res: '0});
    dir_rows.push_back('{frame: '{20'hAAAAA, 20'h55555, 16'hAAAA}, fixed: 1'b0, res: '0});
    foreach (dir_rows[i]) send_frame(dir_rows[i].frame);
    drain();

    // Extreme calibration words
    write_cal(CFG_TEMP, '1); write_cal(CFG_PRESS_LOW, '1); write_cal(CFG_PRESS_HIGH, '1);
    write_cal(CFG_PRESS_NINE, '1); write_cal(CFG_HUM_LOW, '1); write_cal(CFG_HUM_HIGH, '1);
    send_frame('{20'hFFFFF, 20'd0, 16'hFFFF});
    send_frame('{20'd0, 20'hFFFFF, 16'd0});
    drain();
    write_cal(CFG_TEMP, 64'h8000_0000_8000); write_cal(CFG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
    write_cal(CFG_PRESS_HIGH, 64'h8000_8000_8000_8000); write_cal(CFG_PRESS_NINE, 64'h8000);
    write_cal(CFG_HUM_LOW, 64'hFF80_00FF); write_cal(CFG_HUM_HIGH, 64'h80_8000_8000);
    send_frame('{20'h7FFFF, 20'h80000, 16'h8000});
    send_frame('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    drain();

    // Random phases: mostly realistic calibration, some fully random
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) load_random(); else load_typical();
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          fr.at = 20'd400000 + 20'($urandom_range(0, 250000));
          fr.ap = 20'd250000 + 20'($urandom_range(0, 300000));
          fr.ah = 16'($urandom_range(15000, 45000));
        end else begin
          fr = frame_t'(56'({$urandom, $urandom}));
        end
        send_frame(fr);
        // Hold off once until the pipeline is empty
        if (ph == 1 && i == 40) begin
          smp_if.valid <= 1'b0;
          while (expected_q.size() != 0) @(negedge clk_i);
        end
      end
      drain();
    end

    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
